/* rtl/efp_pkg.sv */
// types, constants and helpers shared by the encoder poll frame parser
`timescale 1ns / 1ps

package efp_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_SILENT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HUNT = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef enum logic {
    JOB_TX     = 1'b0,
    JOB_REPORT = 1'b1
  } job_e;

  localparam logic       KIND_TX     = 1'b0;
  localparam logic       KIND_REPORT = 1'b1;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_NODE       = 2'd1;
  localparam logic [1:0] ERR_NO_REPLY   = 2'd2;
  localparam logic [1:0] ERR_CORRUPTED  = 2'd3;

  localparam logic       REG_SYNC_LIMIT   = 1'b0;
  localparam logic       REG_HIGHEST_NODE = 1'b1;

  localparam logic [7:0] SYNC_LIMIT_RESET   = 8'd50;
  localparam logic [3:0] HIGHEST_NODE_RESET = 4'd9;

  localparam logic [7:0] CH_SYNC = 8'h3E;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NL   = 8'h0A;

  localparam logic [3:0] BODY_LEN       = 4'd14;
  localparam logic [3:0] POS_FIRST      = 4'd4;
  localparam logic [3:0] POS_LAST       = 4'd7;
  localparam logic [3:0] STAT_FIRST     = 4'd10;
  localparam logic [3:0] STAT_LAST      = 4'd13;

  localparam logic signed [24:0] ANGLE_MUL = 25'sd360;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    job_e        kind;
    logic [1:0]  err;
    logic [3:0]  node;
    logic [15:0] pos;
    logic [15:0] status;
  } job_t;

  // bit 4 flags a non-hex character, value then reads as zero
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

/* rtl/efp_front.sv */
// front end: accepts input beats, tracks the poll and queues output jobs
`timescale 1ns / 1ps

module efp_front import efp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       accept_i,
  input  logic [1:0] command_i,
  input  logic [3:0] node_number_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [7:0]  limit_q;
  logic [3:0]  highest_q;
  phase_e      phase_q, phase_d;
  logic [3:0]  node_q, node_d;
  logic [7:0]  hunt_q, hunt_d;
  logic [3:0]  body_q, body_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] stat_q, stat_d;
  logic        bad_q, bad_d;

  logic [7:0]  hunt_inc;
  logic [7:0]  lim;
  logic [3:0]  body_inc;
  logic [4:0]  dec;
  logic        in_pos, in_stat;
  logic        bad_new;
  logic [15:0] pos_new, stat_new;

  assign hunt_inc = hunt_q + 8'd1;
  assign lim      = (limit_q == 8'd0) ? 8'd1 : limit_q;
  assign body_inc = body_q + 4'd1;
  assign dec      = hex_decode(rx_byte_i);
  assign in_pos   = (body_q >= POS_FIRST) && (body_q <= POS_LAST);
  assign in_stat  = (body_q >= STAT_FIRST) && (body_q <= STAT_LAST);
  assign bad_new  = bad_q | ((in_pos | in_stat) & dec[4]);
  assign pos_new  = in_pos ? {pos_q[11:0], dec[3:0]} : pos_q;
  assign stat_new = in_stat ? {stat_q[11:0], dec[3:0]} : stat_q;

  always_comb begin
    phase_d = phase_q;
    node_d  = node_q;
    hunt_d  = hunt_q;
    body_d  = body_q;
    pos_d   = pos_q;
    stat_d  = stat_q;
    bad_d   = bad_q;
    push_o  = 1'b0;
    job_o   = '0;
    if (accept_i) begin
      case (cmd_e'(command_i))
        CMD_START: begin
          push_o = 1'b1;
          if (node_number_i > highest_q) begin
            job_o.kind = JOB_REPORT;
            job_o.err  = ERR_NODE;
            job_o.node = node_number_i;
          end else begin
            job_o.kind = JOB_TX;
            job_o.node = node_number_i;
            node_d  = node_number_i;
            phase_d = PH_HUNT;
            hunt_d  = '0;
            body_d  = '0;
            pos_d   = '0;
            stat_d  = '0;
            bad_d   = 1'b0;
          end
        end
        CMD_BYTE: begin
          case (phase_q)
            PH_HUNT: begin
              hunt_d = hunt_inc;
              if (rx_byte_i == CH_SYNC) begin
                phase_d = PH_BODY;
                body_d  = '0;
                pos_d   = '0;
                stat_d  = '0;
                bad_d   = 1'b0;
              end else if (hunt_inc >= lim) begin
                phase_d    = PH_IDLE;
                push_o     = 1'b1;
                job_o.kind = JOB_REPORT;
                job_o.err  = ERR_CORRUPTED;
                job_o.node = node_q;
              end
            end
            PH_BODY: begin
              pos_d  = pos_new;
              stat_d = stat_new;
              bad_d  = bad_new;
              body_d = body_inc;
              if (body_inc >= BODY_LEN) begin
                phase_d    = PH_IDLE;
                body_d     = '0;
                push_o     = 1'b1;
                job_o.kind = JOB_REPORT;
                job_o.node = node_q;
                if (bad_new) begin
                  job_o.err = ERR_CORRUPTED;
                end else begin
                  job_o.err    = ERR_OK;
                  job_o.pos    = pos_new;
                  job_o.status = stat_new;
                end
              end
            end
            default: begin
            end
          endcase
        end
        CMD_SILENT: begin
          case (phase_q)
            PH_HUNT: begin
              phase_d    = PH_IDLE;
              push_o     = 1'b1;
              job_o.kind = JOB_REPORT;
              job_o.err  = ERR_NO_REPLY;
              job_o.node = node_q;
            end
            PH_BODY: begin
              phase_d    = PH_IDLE;
              push_o     = 1'b1;
              job_o.kind = JOB_REPORT;
              job_o.err  = ERR_CORRUPTED;
              job_o.node = node_q;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= SYNC_LIMIT_RESET;
      highest_q <= HIGHEST_NODE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC_LIMIT:   limit_q   <= cfg_data_i;
        REG_HIGHEST_NODE: highest_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      node_q  <= '0;
      hunt_q  <= '0;
      body_q  <= '0;
      pos_q   <= '0;
      stat_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      node_q  <= node_d;
      hunt_q  <= hunt_d;
      body_q  <= body_d;
      pos_q   <= pos_d;
      stat_q  <= stat_d;
      bad_q   <= bad_d;
    end
  end

  a_body_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    body_q < BODY_LEN) else $error("body count past frame length");

endmodule

/* rtl/efp_queue.sv */
// short job queue between front and back end
`timescale 1ns / 1ps

module efp_queue import efp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t head_o
);

  job_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH)) else $error("queue overfilled");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

endmodule

/* rtl/efp_back.sv */
// back end: expands queued jobs into output beats behind a register
`timescale 1ns / 1ps

module efp_back import efp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  job_t               head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [7:0]         tx_byte_o,
  output logic               last_of_run_o,
  output logic [1:0]         error_code_o,
  output logic [3:0]         node_reported_o,
  output logic signed [15:0] position_raw_o,
  output logic [15:0]        status_word_o,
  output logic signed [24:0] angle_scaled_o
);

  logic        valid_q;
  logic [1:0]  idx_q, idx_d;
  logic        load;
  logic [7:0]  tx_sel;
  logic signed [24:0] pos_wide;
  logic signed [24:0] angle;

  assign load     = !empty_i && (!valid_q || !out_stall_i);
  assign pos_wide = 25'(signed'(head_i.pos));
  assign angle    = pos_wide * ANGLE_MUL;

  always_comb begin
    case (idx_q)
      2'd0:    tx_sel = CH_HASH;
      2'd1:    tx_sel = CH_ZERO + {4'd0, head_i.node};
      default: tx_sel = CH_NL;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    pop_o = 1'b0;
    if (load) begin
      if (head_i.kind == JOB_TX) begin
        if (idx_q == 2'd2) begin
          idx_d = 2'd0;
          pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end else begin
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_i.kind == JOB_TX) begin
        kind_o          <= KIND_TX;
        tx_byte_o       <= tx_sel;
        last_of_run_o   <= (idx_q == 2'd2);
        error_code_o    <= ERR_OK;
        node_reported_o <= '0;
        position_raw_o  <= '0;
        status_word_o   <= '0;
        angle_scaled_o  <= '0;
      end else begin
        kind_o          <= KIND_REPORT;
        tx_byte_o       <= '0;
        last_of_run_o   <= 1'b1;
        error_code_o    <= head_i.err;
        node_reported_o <= head_i.node;
        position_raw_o  <= signed'(head_i.pos);
        status_word_o   <= head_i.status;
        angle_scaled_o  <= angle;
      end
    end
  end

  assign out_valid_o = valid_q;

  a_idx_tx_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> !empty_i && head_i.kind == JOB_TX)
    else $error("query sequence lost its job");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3) else $error("query beat index out of range");

endmodule

/* rtl/encoder_poll_frame_parser_unit.sv */
// top level of the encoder poll frame parser
// channel   dir  handshake              payload
// in        in   in_valid_i/in_stall_o  command_i, node_number_i, rx_byte_i
// out       out  out_valid_o/out_stall_i kind_o .. angle_scaled_o
// cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
// one input beat per cycle unless stalled, decoded in the accepting cycle
// valid start: three output beats, one per cycle unless stalled; report: one
// the four-deep job queue stalls input only when full; output is registered
// asynchronous active-low reset loads register defaults and idles the poll
`timescale 1ns / 1ps

module encoder_poll_frame_parser_unit import efp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [3:0]         node_number_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [7:0]         tx_byte_o,
  output logic               last_of_run_o,
  output logic [1:0]         error_code_o,
  output logic [3:0]         node_reported_o,
  output logic signed [15:0] position_raw_o,
  output logic [15:0]        status_word_o,
  output logic signed [24:0] angle_scaled_o
);

  logic accept;
  logic push, pop, full, empty;
  job_t job, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  efp_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .accept_i      (accept),
    .command_i,
    .node_number_i,
    .rx_byte_i,
    .push_o        (push),
    .job_o         (job)
  );

  efp_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  efp_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .tx_byte_o,
    .last_of_run_o,
    .error_code_o,
    .node_reported_o,
    .position_raw_o,
    .status_word_o,
    .angle_scaled_o
  );

endmodule

/* tb/tb.sv */
// self-checking testbench for the encoder poll frame parser unit
`timescale 1ns / 1ps

module tb;
  import efp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 50;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic [1:0]  err;
    logic [3:0]  node;
    logic [15:0] pos;
    logic [15:0] stat;
    logic [24:0] angle;
  } poll_beat_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] node;
    logic [7:0] data;
    logic       typed;
    poll_beat_t want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [7:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         command_i;
  logic [3:0]         node_number_i;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               kind_o;
  logic [7:0]         tx_byte_o;
  logic               last_of_run_o;
  logic [1:0]         error_code_o;
  logic [3:0]         node_reported_o;
  logic signed [15:0] position_raw_o;
  logic [15:0]        status_word_o;
  logic signed [24:0] angle_scaled_o;

  encoder_poll_frame_parser_unit dut (.*);

  // poll state as the parser should hold it
  phase_e      poll_phase = PH_IDLE;
  logic [3:0]  poll_node = '0;
  logic [7:0]  hunt_seen = '0;
  logic [3:0]  body_idx = '0;
  logic [15:0] pos_word = '0;
  logic [15:0] stat_word = '0;
  logic        digit_bad = 1'b0;
  logic [7:0]  sync_lim = SYNC_LIMIT_RESET;
  logic [3:0]  top_node = HIGHEST_NODE_RESET;

  poll_beat_t beats_due[$];
  poll_beat_t step_beats[$];
  dir_row_t   dir_rows[$];
  bit         took_effect;
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_off_req = 1'b0;
  int         live_items = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic poll_beat_t tx_beat(input logic [7:0] b, input logic last);
    poll_beat_t r;
    r = '0;
    r.kind = KIND_TX;
    r.tx = b;
    r.last = last;
    return r;
  endfunction

  function automatic poll_beat_t report_beat(input logic [1:0] err, input logic [3:0] node,
                                             input logic [15:0] pos, input logic [15:0] stat,
                                             input logic [24:0] angle);
    poll_beat_t r;
    r.kind = KIND_REPORT;
    r.tx = '0;
    r.last = 1'b1;
    r.err = err;
    r.node = node;
    r.pos = pos;
    r.stat = stat;
    r.angle = angle;
    return r;
  endfunction

  function automatic poll_beat_t report_of(input logic [1:0] err, input logic [3:0] node);
    int degrees;
    if (err != ERR_OK) return report_beat(err, node, '0, '0, '0);
    degrees = $signed(pos_word) * 360;
    return report_beat(err, node, pos_word, stat_word, 25'(degrees));
  endfunction

  // bit 4 set marks a character that is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b0, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  task automatic advance_poll(input logic [1:0] cmd, input logic [3:0] node,
                              input logic [7:0] b);
    logic [7:0] lim;
    logic [4:0] d;
    logic [3:0] off;
    step_beats.delete();
    took_effect = 1'b1;
    lim = (sync_lim == 8'd0) ? 8'd1 : sync_lim;
    case (cmd)
      CMD_START: begin
        if (node > top_node) begin
          step_beats.push_back(report_of(ERR_NODE, node));
        end else begin
          poll_node = node;
          poll_phase = PH_HUNT;
          hunt_seen = '0;
          body_idx = '0;
          pos_word = '0;
          stat_word = '0;
          digit_bad = 1'b0;
          step_beats.push_back(tx_beat(CH_HASH, 1'b0));
          step_beats.push_back(tx_beat(CH_ZERO + 8'(node), 1'b0));
          step_beats.push_back(tx_beat(CH_NL, 1'b1));
        end
      end
      CMD_BYTE: begin
        if (poll_phase == PH_HUNT) begin
          hunt_seen = hunt_seen + 8'd1;
          if (b == CH_SYNC) begin
            poll_phase = PH_BODY;
            body_idx = '0;
            pos_word = '0;
            stat_word = '0;
            digit_bad = 1'b0;
          end else if (hunt_seen >= lim) begin
            poll_phase = PH_IDLE;
            step_beats.push_back(report_of(ERR_CORRUPTED, poll_node));
          end
        end else if (poll_phase == PH_BODY) begin
          off = body_idx;
          if (off inside {[POS_FIRST:POS_LAST], [STAT_FIRST:STAT_LAST]}) begin
            d = hex_digit(b);
            if (d[4]) begin
              digit_bad = 1'b1;
              d = '0;
            end
            if (off <= POS_LAST) pos_word = {pos_word[11:0], d[3:0]};
            else stat_word = {stat_word[11:0], d[3:0]};
          end
          body_idx = body_idx + 4'd1;
          if (body_idx >= BODY_LEN) begin
            poll_phase = PH_IDLE;
            body_idx = '0;
            step_beats.push_back(report_of(digit_bad ? ERR_CORRUPTED : ERR_OK, poll_node));
          end
        end else begin
          took_effect = 1'b0;
        end
      end
      CMD_SILENT: begin
        if (poll_phase == PH_HUNT) begin
          step_beats.push_back(report_of(ERR_NO_REPLY, poll_node));
        end else if (poll_phase == PH_BODY) begin
          step_beats.push_back(report_of(ERR_CORRUPTED, poll_node));
        end else begin
          took_effect = 1'b0;
        end
        poll_phase = PH_IDLE;
      end
      default: took_effect = 1'b0;
    endcase
  endtask

  // offers one beat, returns at the falling edge after it was taken
  task automatic drive_beat(input logic [1:0] cmd, input logic [3:0] node,
                            input logic [7:0] b, input bit typed = 1'b0,
                            input poll_beat_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      command_i = 2'($urandom);
      node_number_i = 4'($urandom);
      rx_byte_i = 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i = cmd;
    node_number_i = node;
    rx_byte_i = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_poll(cmd, node, b);
    if (took_effect) live_items++;
    if (typed) beats_due.push_back(want);
    else foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
    @(negedge clk_i);
  endtask

  task automatic quiet_until_drained(input int extra);
    in_valid_i = 1'b0;
    while (beats_due.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_SYNC_LIMIT) sync_lim = data;
    else top_node = data[3:0];
  endtask

  function automatic dir_row_t mk_row(input logic [1:0] cmd, input logic [3:0] node,
                                      input logic [7:0] data, input logic typed = 1'b0,
                                      input poll_beat_t want = '0);
    dir_row_t r;
    r.cmd = cmd;
    r.node = node;
    r.data = data;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic logic [7:0] body_char(input int off);
    logic [7:0] c;
    logic [4:0] d;
    logic [3:0] v;
    if (!(off inside {[POS_FIRST:POS_LAST], [STAT_FIRST:STAT_LAST]})) return 8'($urandom);
    if ($urandom_range(99) < 4) begin
      do begin
        c = 8'($urandom);
        d = hex_digit(c);
      end while (!d[4]);
      return c;
    end
    v = 4'($urandom);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 4'd10);
  endfunction

  // mostly well-formed polls with random content, some noise and broken frames
  task automatic run_poll_sequence();
    logic [3:0] n;
    logic [7:0] b;
    int lim;
    int noise;
    int mode;
    int brk;
    lim = (sync_lim == 8'd0) ? 1 : int'(sync_lim);
    if ($urandom_range(99) < 12) begin
      drive_beat(2'($urandom), 4'($urandom), 8'($urandom));
      return;
    end
    n = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(0, int'(top_node)));
    drive_beat(CMD_START, n, 8'($urandom));
    if (n > top_node) return;
    mode = $urandom_range(99);
    noise = (mode < 10 && lim <= 24) ? lim : $urandom_range(0, 3);
    for (int i = 0; i < noise; i++) begin
      do b = 8'($urandom); while (b == CH_SYNC);
      drive_beat(CMD_BYTE, 4'($urandom), b);
    end
    if (noise >= lim) return;
    if (mode >= 10 && mode < 16) begin
      drive_beat(CMD_SILENT, 4'($urandom), 8'($urandom));
      return;
    end
    drive_beat(CMD_BYTE, 4'($urandom), CH_SYNC);
    brk = (mode >= 16 && mode < 28) ? $urandom_range(0, 13) : int'(BODY_LEN);
    for (int off = 0; off < int'(BODY_LEN); off++) begin
      if (off == brk) begin
        if ($urandom_range(1)) drive_beat(CMD_SILENT, 4'($urandom), 8'($urandom));
        else drive_beat(CMD_START, 4'($urandom_range(0, int'(top_node))), 8'($urandom));
        return;
      end
      drive_beat(CMD_BYTE, 4'($urandom), body_char(off));
    end
  endtask

  // receiver side
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [24:0] want,
                             input logic [24:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    poll_beat_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (beats_due.size() == 0) begin
        $error("output beat with nothing expected");
        fail_count++;
      end else begin
        w = beats_due.pop_front();
        check_field("kind", 25'(w.kind), 25'(kind_o));
        check_field("tx_byte", 25'(w.tx), 25'(tx_byte_o));
        check_field("last_of_run", 25'(w.last), 25'(last_of_run_o));
        check_field("error_code", 25'(w.err), 25'(error_code_o));
        check_field("node_reported", 25'(w.node), 25'(node_reported_o));
        check_field("position_raw", 25'(w.pos), 25'($unsigned(position_raw_o)));
        check_field("status_word", 25'(w.stat), 25'(status_word_o));
        check_field("angle_scaled", w.angle, $unsigned(angle_scaled_o));
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int lim_set[5];
    int top_set[5];
    int send_set[5];
    int recv_set[5];
    int phase_start;
    bit paused;
    dir_row_t r;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = '0;
    node_number_i = '0;
    rx_byte_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part under the reset register values
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h78));
    dir_rows.push_back(mk_row(CMD_SILENT, 4'd0, 8'h00));
    dir_rows.push_back(mk_row(CMD_UNUSED, 4'd5, CH_SYNC));
    dir_rows.push_back(mk_row(CMD_START, 4'd15, 8'hFF, 1'b1,
                              report_beat(ERR_NODE, 4'd15, '0, '0, '0)));
    dir_rows.push_back(mk_row(CMD_START, 4'd9, 8'h00));
    dir_rows.push_back(mk_row(CMD_SILENT, 4'd0, 8'h00, 1'b1,
                              report_beat(ERR_NO_REPLY, 4'd9, '0, '0, '0)));
    dir_rows.push_back(mk_row(CMD_START, 4'd0, 8'h00));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, CH_SYNC));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h00));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'hFF));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, CH_SYNC));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h20));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h38));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h30));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h30));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h30));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h7A));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'hFF));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h66));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h46));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h66));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, 8'h46, 1'b1,
                              report_beat(ERR_OK, 4'd0, 16'h8000, 16'hFFFF, 25'h14C0000)));
    dir_rows.push_back(mk_row(CMD_START, 4'd3, 8'h00));
    dir_rows.push_back(mk_row(CMD_BYTE, 4'd0, CH_SYNC));
    dir_rows.push_back(mk_row(CMD_SILENT, 4'd0, 8'h00, 1'b1,
                              report_beat(ERR_CORRUPTED, 4'd3, '0, '0, '0)));
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      drive_beat(r.cmd, r.node, r.data, r.typed, r.want);
    end

    // random part: hold-off only, sender idle, receiver stall, both, none again
    lim_set = '{255, 1, 0, 20, $urandom_range(2, 60)};
    top_set = '{15, 0, 7, 15, $urandom_range(0, 15)};
    send_set = '{0, 47, 0, 34, 0};
    recv_set = '{0, 0, 47, 34, 0};
    for (int ph = 0; ph < 5; ph++) begin
      quiet_until_drained(6);
      write_reg(REG_SYNC_LIMIT, 8'(lim_set[ph]));
      write_reg(REG_HIGHEST_NODE, {4'($urandom), 4'(top_set[ph])});
      send_idle_pct = send_set[ph];
      recv_stall_pct = recv_set[ph];
      if (ph == 0) hold_off_req = 1'b1;
      phase_start = live_items;
      paused = 1'b0;
      while (live_items - phase_start < ITEMS_PER_PHASE) begin
        run_poll_sequence();
        if (ph == 1 && !paused && live_items - phase_start >= ITEMS_PER_PHASE / 2) begin
          quiet_until_drained(1);
          paused = 1'b1;
        end
      end
    end

    quiet_until_drained(20);
    if (fail_count == 0 && beats_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/efp_pkg.sv
rtl/efp_front.sv
rtl/efp_queue.sv
rtl/efp_back.sv
rtl/encoder_poll_frame_parser_unit.sv
tb/tb.sv
